// ===== design/twc_pkg.sv =====
// Shared types and constants for the trie word counter.
// Holds the command, status and state codes and the payload structs.
// No dependencies.
package twc_pkg;

  localparam int NODES_DEF      = 4096;
  localparam int ALPHABET_DEF   = 26;
  localparam int COUNT_BITS_DEF = 16;

  localparam int OUT_COUNT_W = 16;
  localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = {OUT_COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_POOL_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LINK = 2'd1,
    S_NODE = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] letter;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   found;
    logic [OUT_COUNT_W-1:0] word_count;
  } out_item_t;

endpackage

// ===== design/twc_store.sv =====
// Node pool storage for the trie word counter: the child link memory and
// the per-node memory holding the back pointer and the word count.
// Standalone; both memories have one write port and a registered read.
module twc_store #(
  parameter int NODES      = 4096,
  parameter int ALPHABET   = 26,
  parameter int COUNT_BITS = 16,
  localparam int NW  = $clog2(NODES),
  localparam int LA  = $clog2(NODES * ALPHABET),
  localparam int NDW = LA + COUNT_BITS
) (
  input  logic           clk,
  input  logic           link_re,
  input  logic [LA-1:0]  link_raddr,
  output logic [NW-1:0]  link_rdata,
  input  logic           link_we,
  input  logic [LA-1:0]  link_waddr,
  input  logic [NW-1:0]  link_wdata,
  input  logic           node_re,
  input  logic [NW-1:0]  node_raddr,
  output logic [NDW-1:0] node_rdata,
  input  logic           node_we,
  input  logic [NW-1:0]  node_waddr,
  input  logic [NDW-1:0] node_wdata
);

  logic [NW-1:0]  link_mem [NODES * ALPHABET];
  logic [NDW-1:0] node_mem [NODES];

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rdata <= node_mem[node_raddr];
    end
  end

endmodule

// ===== design/trie_word_counter_unit.sv =====
// Top level of the trie word counter: command decode, the walk sequencer
// and the result register. Depends on twc_pkg and instantiates twc_store.
//
//   Channel   Ports                        Transfer
//   input     start, busy, in_item         start high while busy is low
//   result    out_valid, out_item          out_valid high for one cycle
//
// A letter that walks the trie is first accepted, which reads the child
// link of the current node; S_LINK then reads the node record of that
// child, and S_NODE decides, writes back and registers the result. Busy is
// high in S_LINK and S_NODE. A clear, a letter past the end of the alphabet,
// or a letter of a word that has already failed, is settled in its accept
// cycle and leaves busy low.
// Reset is synchronous and active low; it empties the trie at once with
// no sweep, since validity of a link is checked against the node pool.
// The receiver cannot stall: each result shows for exactly one cycle.
module trie_word_counter_unit #(
  parameter int NODES      = twc_pkg::NODES_DEF,
  parameter int ALPHABET   = twc_pkg::ALPHABET_DEF,
  parameter int COUNT_BITS = twc_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  twc_pkg::in_item_t   in_item,
  output logic                out_valid,
  output twc_pkg::out_item_t  out_item
);

  import twc_pkg::*;

  // Node index, fill count, link address and node record widths.
  localparam int NW  = $clog2(NODES);
  localparam int FW  = $clog2(NODES + 1);
  localparam int LA  = $clog2(NODES * ALPHABET);
  localparam int NDW = LA + COUNT_BITS;
  localparam int CE  = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

  // A link is trusted only when its child lies below the fill count and
  // that child's back pointer names the very slot the link was read from.
  // Every non-root node below the fill count was written at its allocation in the
  // current pool, so stale links from before a clear never pass.

  state_t            state_r, state_nxt;
  logic [NW-1:0]     cursor_r, cursor_nxt;
  logic [FW-1:0]     next_free_r, next_free_nxt;
  logic              word_failed_r, word_failed_nxt;
  status_t           fail_code_r, fail_code_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic              last_r, last_nxt;
  logic [LA-1:0]     slot_r, slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              in_fire;
  cmd_t              in_cmd;
  logic              in_letter_bad;
  logic              in_walk;
  logic [LA-1:0]     in_slot;

  logic              link_re, link_we, node_re, node_we;
  logic [NW-1:0]     link_rdata, link_wdata;
  logic [NDW-1:0]    node_rdata, node_wdata;
  logic [NW-1:0]     node_waddr;

  logic [LA-1:0]         rd_back;
  logic [COUNT_BITS-1:0] rd_count;
  logic                  hit;
  logic                  can_alloc;
  logic [NW-1:0]         child;
  logic [COUNT_BITS-1:0] cnt_cur, cnt_new;
  logic [CE-1:0]         cnt_ext;

  assign in_cmd        = cmd_t'(in_item.command);
  assign in_fire       = start && (state_r == S_IDLE);
  assign in_letter_bad = 32'(in_item.letter) >= 32'(ALPHABET);
  assign in_walk       = in_fire && (in_cmd != CMD_CLEAR) && !word_failed_r
                         && !in_letter_bad;
  assign in_slot       = LA'(cursor_r) * LA'(ALPHABET) + LA'(in_item.letter);

  assign rd_back  = node_rdata[NDW-1:COUNT_BITS];
  assign rd_count = node_rdata[COUNT_BITS-1:0];

  twc_store #(
    .NODES      (NODES),
    .ALPHABET   (ALPHABET),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk        (clk),
    .link_re    (link_re),
    .link_raddr (in_slot),
    .link_rdata (link_rdata),
    .link_we    (link_we),
    .link_waddr (slot_r),
    .link_wdata (link_wdata),
    .node_re    (node_re),
    .node_raddr (link_rdata),
    .node_rdata (node_rdata),
    .node_we    (node_we),
    .node_waddr (node_waddr),
    .node_wdata (node_wdata)
  );

  // Next state of the walk sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_walk) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK:  state_nxt = S_NODE;
      S_NODE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Link check and allocation decision for the letter in the node stage.
  always_comb begin
    hit = 1'b0;
    if ((link_rdata != '0) && (FW'(link_rdata) < next_free_r) &&
        (rd_back == slot_r)) begin
      hit = 1'b1;
    end
    can_alloc = (cmd_r == CMD_INSERT) && (next_free_r < FW'(NODES));
    child     = hit ? link_rdata : NW'(next_free_r);
    cnt_cur   = hit ? rd_count : '0;
    if (cmd_r == CMD_DELETE) begin
      cnt_new = cnt_cur - 1'b1;
    end else if ((cmd_r == CMD_INSERT) && (cnt_cur != '1)) begin
      cnt_new = cnt_cur + 1'b1;
    end else begin
      cnt_new = cnt_cur;
    end
    cnt_ext = CE'(cnt_new);
  end

  // Register updates, memory accesses and the result.
  always_comb begin
    cursor_nxt      = cursor_r;
    next_free_nxt   = next_free_r;
    word_failed_nxt = word_failed_r;
    fail_code_nxt   = fail_code_r;
    cmd_nxt         = cmd_r;
    last_nxt        = last_r;
    slot_nxt        = slot_r;
    out_valid_nxt   = 1'b0;
    out_item_nxt    = '0;
    link_re         = 1'b0;
    link_we         = 1'b0;
    link_wdata      = NW'(next_free_r);
    node_re         = 1'b0;
    node_we         = 1'b0;
    node_waddr      = child;
    node_wdata      = {slot_r, {COUNT_BITS{1'b0}}};

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_CLEAR) begin
            // A clear without the final mark is dropped.
            if (in_item.last) begin
              next_free_nxt   = FW'(1);
              cursor_nxt      = '0;
              word_failed_nxt = 1'b0;
              fail_code_nxt   = ST_OK;
              out_valid_nxt   = 1'b1;
            end
          end else if (word_failed_r || in_letter_bad) begin
            if (in_item.last) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = word_failed_r ? fail_code_r : ST_NOT_FOUND;
              cursor_nxt          = '0;
              word_failed_nxt     = 1'b0;
              fail_code_nxt       = ST_OK;
            end else if (!word_failed_r) begin
              word_failed_nxt = 1'b1;
              fail_code_nxt   = ST_NOT_FOUND;
            end
          end else begin
            link_re  = 1'b1;
            cmd_nxt  = in_cmd;
            last_nxt = in_item.last;
            slot_nxt = in_slot;
          end
        end
      end

      S_LINK: begin
        node_re = 1'b1;
      end

      S_NODE: begin
        if (hit || can_alloc) begin
          if (!hit) begin
            link_we       = 1'b1;
            node_we       = 1'b1;
            next_free_nxt = next_free_r + 1'b1;
          end
          if (!last_r) begin
            cursor_nxt = child;
          end else begin
            cursor_nxt    = '0;
            out_valid_nxt = 1'b1;
            if ((cmd_r != CMD_INSERT) && (cnt_cur == '0)) begin
              out_item_nxt.status = ST_NOT_FOUND;
            end else begin
              out_item_nxt.found      = (cmd_r == CMD_FIND);
              out_item_nxt.word_count = (cnt_ext > CE'(OUT_COUNT_MAX)) ?
                                        OUT_COUNT_MAX : OUT_COUNT_W'(cnt_ext);
              if (cmd_r != CMD_FIND) begin
                node_we    = 1'b1;
                node_wdata = {slot_r, cnt_new};
              end
            end
          end
        end else begin
          if (last_r) begin
            cursor_nxt          = '0;
            out_valid_nxt       = 1'b1;
            out_item_nxt.status = (cmd_r == CMD_INSERT) ? ST_POOL_FULL
                                                        : ST_NOT_FOUND;
          end else begin
            word_failed_nxt = 1'b1;
            fail_code_nxt   = (cmd_r == CMD_INSERT) ? ST_POOL_FULL : ST_NOT_FOUND;
          end
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cursor_r      <= '0;
      next_free_r   <= FW'(1);
      word_failed_r <= 1'b0;
      fail_code_r   <= ST_OK;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cursor_r      <= cursor_nxt;
      next_free_r   <= next_free_nxt;
      word_failed_r <= word_failed_nxt;
      fail_code_r   <= fail_code_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    last_r     <= last_nxt;
    slot_r     <= slot_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // The pool fill count always stays between one and the pool size.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_free_r >= FW'(1)) && (next_free_r <= FW'(NODES)))
    else $error("node pool fill count out of range");

  // The walk cursor always points at an allocated node or the root.
  a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    FW'(cursor_r) < next_free_r)
    else $error("cursor points past the allocated nodes");

  // A pool_full result can only come from an exhausted pool.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_POOL_FULL) |-> next_free_r == FW'(NODES))
    else $error("pool_full reported with free nodes left");

  // A found word is reported ok with a nonzero count.
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.found |->
      (out_item.status == ST_OK) && (out_item.word_count != '0))
    else $error("found result with bad status or zero count");

  // A completed clear transfer empties the pool on the next edge.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.command == CMD_CLEAR) && in_item.last |=>
      (next_free_r == FW'(1)) && (cursor_r == '0) && !word_failed_r)
    else $error("clear did not empty the trie");
`endif

endmodule
